### rtl/mexp_pkg.sv
// shared constants for the modular exponentiation block
// no dependencies
package mexp_pkg;
    localparam int W      = 32;
    localparam int CNT_W  = $clog2(W);
    localparam int CFG_IW = 1;

    localparam logic [CFG_IW-1:0] REG_MODULUS  = 1'b0;
    localparam logic [CFG_IW-1:0] REG_EXPONENT = 1'b1;
endpackage

### rtl/modular_exponentiation.sv
// modular exponentiation top level: sequencer and bit-serial modular multiplier
// depends on mexp_pkg
//
// Computes base^exponent mod modulus by right-to-left square-and-multiply.
// One shared interleaved modular multiplier consumes one multiplier bit per
// cycle of its W-bit multiplier (W = 32). An item first gets its base
// reduced, then for each exponent bit up to its highest set bit there is a
// check step, a multiply when the bit is one and a square except after the
// top bit. One transaction is in flight at a time; the next input is taken
// as soon as the finished result sits in the output register. A zero
// exponent gives 1 unreduced; a zero modulus gives 0 with o_modulus_error
// set. The user must write the registers only while idle; the block itself
// does not enforce this.
module modular_exponentiation
    import mexp_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [CFG_IW-1:0] i_cfg_index,
    input  logic [W-1:0]      i_cfg_data,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  logic [W-1:0]      i_base_value,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output logic [W-1:0]      o_power_result,
    output logic              o_modulus_error
);
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_RED  = 3'd1;
    localparam logic [2:0] S_CHK  = 3'd2;
    localparam logic [2:0] S_MUL  = 3'd3;
    localparam logic [2:0] S_SQR  = 3'd4;
    localparam logic [2:0] S_OUT  = 3'd5;

    logic [2:0]       r_state, n_state;
    logic [W-1:0]     r_modulus, n_modulus;
    logic [W-1:0]     r_exponent, n_exponent;
    logic [W-1:0]     r_exp, n_exp;
    logic [W-1:0]     r_base, n_base;
    logic [W-1:0]     r_acc, n_acc;
    logic             r_err, n_err;
    logic [W-1:0]     r_mac, n_mac;
    logic [W-1:0]     r_mplr, n_mplr;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             r_out_valid, n_out_valid;
    logic [W-1:0]     r_out_res, n_out_res;
    logic             r_out_err, n_out_err;

    logic [W-1:0] op_a;
    logic [W:0]   dbl, dbl_red, sum, sum_red;
    logic         in_acc;

    // one interleaved step: mac = (2*mac + bit*a) mod m
    always_comb begin
        unique case (r_state)
            S_RED:   op_a = W'(1);
            S_MUL:   op_a = r_acc;
            default: op_a = r_base;
        endcase
        dbl     = {r_mac, 1'b0};
        dbl_red = (dbl >= {1'b0, r_modulus}) ? dbl - {1'b0, r_modulus} : dbl;
        sum     = {1'b0, dbl_red[W-1:0]} + (r_mplr[W-1] ? {1'b0, op_a} : '0);
        sum_red = (sum >= {1'b0, r_modulus}) ? sum - {1'b0, r_modulus} : sum;
    end

    assign o_in_stall = (r_state != S_IDLE);
    assign in_acc     = i_in_valid && !o_in_stall;

    always_comb begin
        n_state     = r_state;
        n_modulus   = r_modulus;
        n_exponent  = r_exponent;
        n_exp       = r_exp;
        n_base      = r_base;
        n_acc       = r_acc;
        n_err       = r_err;
        n_mac       = r_mac;
        n_mplr      = r_mplr;
        n_cnt       = r_cnt;
        n_out_valid = r_out_valid && i_out_stall;
        n_out_res   = r_out_res;
        n_out_err   = r_out_err;

        if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_MODULUS:  n_modulus  = i_cfg_data;
                REG_EXPONENT: n_exponent = i_cfg_data;
            endcase
        end

        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_exp  = r_exponent;
                    n_mplr = i_base_value;
                    n_mac  = '0;
                    n_cnt  = CNT_W'(W - 1);
                    if (r_modulus == '0) begin
                        n_acc   = '0;
                        n_err   = 1'b1;
                        n_state = S_OUT;
                    end else begin
                        n_acc   = W'(1);
                        n_err   = 1'b0;
                        n_state = S_RED;
                    end
                end
            end
            S_RED, S_MUL, S_SQR: begin
                n_mac  = sum_red[W-1:0];
                n_mplr = {r_mplr[W-2:0], 1'b0};
                n_cnt  = r_cnt - CNT_W'(1);
                if (r_cnt == '0) begin
                    n_mac  = '0;
                    n_cnt  = CNT_W'(W - 1);
                    n_mplr = r_base;
                    priority if (r_state == S_RED) begin
                        n_base  = sum_red[W-1:0];
                        n_state = S_CHK;
                    end else if (r_state == S_MUL) begin
                        n_acc = sum_red[W-1:0];
                        if (r_exp[W-1:1] == '0) begin
                            n_exp   = r_exp >> 1;
                            n_state = S_CHK;
                        end else begin
                            n_state = S_SQR;
                        end
                    end else begin
                        n_base  = sum_red[W-1:0];
                        n_mplr  = sum_red[W-1:0];
                        n_exp   = r_exp >> 1;
                        n_state = S_CHK;
                    end
                end
            end
            S_CHK: begin
                n_mplr = r_base;
                n_mac  = '0;
                n_cnt  = CNT_W'(W - 1);
                priority if (r_exp == '0) begin
                    n_state = S_OUT;
                end else if (r_exp[0]) begin
                    n_state = S_MUL;
                end else begin
                    n_state = S_SQR;
                end
            end
            S_OUT: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_out_valid = 1'b1;
                    n_out_res   = r_acc;
                    n_out_err   = r_err;
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_modulus   <= W'(1);
            r_exponent  <= W'(1);
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_modulus   <= n_modulus;
            r_exponent  <= n_exponent;
            r_out_valid <= n_out_valid;
        end
        r_exp     <= n_exp;
        r_base    <= n_base;
        r_acc     <= n_acc;
        r_err     <= n_err;
        r_mac     <= n_mac;
        r_mplr    <= n_mplr;
        r_cnt     <= n_cnt;
        r_out_res <= n_out_res;
        r_out_err <= n_out_err;
    end

    assign o_out_valid     = r_out_valid;
    assign o_power_result  = r_out_res;
    assign o_modulus_error = r_out_err;
endmodule

### rtl/mexp_checker.sv
// port-level checks for the modular exponentiation block, bound to its top level
// depends on mexp_pkg and modular_exponentiation
module mexp_checker
    import mexp_pkg::*;
(
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_in_valid,
    input logic              o_in_stall,
    input logic              o_out_valid,
    input logic              i_out_stall,
    input logic [W-1:0]      o_power_result,
    input logic              o_modulus_error
);
    // stalled result transaction holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_power_result)
            && $stable(o_modulus_error))
        else $error("stalled result changed");

    // error result carries zero
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_modulus_error |-> o_power_result == '0)
        else $error("error result not zero");

    // accepted transaction keeps the block busy
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("input not stalled after accept");

    // a new result only comes out of a busy block
    a_res_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(o_in_stall))
        else $error("result without transaction");
endmodule

bind modular_exponentiation mexp_checker u_mexp_checker (.*);

### tb/tb_top.sv
// self-checking testbench for the modular exponentiation block: directed key cases, then random keys
// and bases under three idling patterns, each result checked against a built-in square-and-multiply
// depends on mexp_pkg and modular_exponentiation
module tb_top;
    import mexp_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int QUIET_LIMIT = 20000;

    typedef struct packed {
        logic [W-1:0] power;
        logic         err;
    } t_power;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_cfg_we = 1'b0;
    logic [CFG_IW-1:0] i_cfg_index = REG_MODULUS;
    logic [W-1:0]      i_cfg_data = '0;
    logic              i_in_valid = 1'b0;
    logic              o_in_stall;
    logic [W-1:0]      i_base_value = '0;
    logic              o_out_valid;
    logic              i_out_stall = 1'b0;
    logic [W-1:0]      o_power_result;
    logic              o_modulus_error;

    logic [W-1:0] key_modulus = 32'd1;
    logic [W-1:0] key_exponent = 32'd1;
    t_power       pending_powers[$];
    int unsigned  send_gap_pct = 0;
    int unsigned  sink_stall_pct = 0;
    int unsigned  mismatch_count = 0;
    int unsigned  quiet_cycles = 0;

    modular_exponentiation uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_base_value    (i_base_value),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_power_result  (o_power_result),
        .o_modulus_error (o_modulus_error)
    );

    always #6 i_clk = ~i_clk;

    function automatic t_power calc_power(logic [W-1:0] base);
        logic [63:0] m;
        logic [63:0] b;
        logic [63:0] acc;
        logic [W-1:0] e;
        t_power r;
        m = 64'(key_modulus);
        e = key_exponent;
        acc = 64'd1;
        r.err = 1'b0;
        if (m == 0) begin
            r.power = '0;
            r.err = 1'b1;
            return r;
        end
        b = 64'(base) % m;
        while (e != 0) begin
            if (e[0]) begin
                acc = (acc * b) % m;
            end
            e = e >> 1;
            b = (b * b) % m;
        end
        r.power = acc[W-1:0];
        return r;
    endfunction

    function automatic logic [W-1:0] rand_exponent(int unsigned bits);
        logic [W-1:0] v;
        v = $urandom;
        if (bits < W) begin
            v = v & ((32'd1 << bits) - 32'd1);
        end
        v[bits-1] = 1'b1;
        return v;
    endfunction

    task automatic send_base(logic [W-1:0] base);
        @(negedge i_clk);
        while ($urandom_range(99) < send_gap_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_base_value <= base;
        do @(posedge i_clk); while (o_in_stall);
        pending_powers.push_back(calc_power(base));
    endtask

    // hold off new transactions until every result is back
    task automatic drain_results();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (pending_powers.size() != 0) @(posedge i_clk);
        repeat (2) @(negedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IW-1:0] idx, logic [W-1:0] data);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == REG_MODULUS) begin
            key_modulus = data;
        end else begin
            key_exponent = data;
        end
    endtask

    task automatic set_key(logic [W-1:0] modulus, logic [W-1:0] exponent);
        drain_results();
        write_reg(REG_MODULUS, modulus);
        write_reg(REG_EXPONENT, exponent);
    endtask

    task automatic test_reset_values();
        send_base(32'd0);
        send_base(32'hFFFF_FFFF);
        send_base(32'd12345);
    endtask

    task automatic test_zero_modulus();
        set_key(32'd0, 32'd5);
        send_base(32'd0);
        send_base(32'hFFFF_FFFF);
        set_key(32'd0, 32'd0);
        send_base(32'd7);
    endtask

    task automatic test_zero_exponent();
        set_key(32'd1, 32'd0);
        send_base(32'hFFFF_FFFF);
        send_base(32'd1);
        set_key(32'hFFFF_FFFF, 32'd0);
        send_base(32'd0);
    endtask

    task automatic test_extremes();
        set_key(32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_base(32'd0);
        send_base(32'd1);
        send_base(32'hFFFF_FFFE);
        send_base(32'hFFFF_FFFF);
        set_key(32'hFFFF_FFFB, 32'hFFFF_FFFA);
        send_base(32'd2);
        send_base(32'hFFFF_FFFB);
        set_key(32'd2, 32'hFFFF_FFFF);
        send_base(32'd3);
    endtask

    task automatic test_rsa_keys();
        set_key(32'd3233, 32'd17);
        send_base(32'd65);
        set_key(32'd3233, 32'd2753);
        send_base(32'd2790);
    endtask

    task automatic test_random(int unsigned n_items);
        int unsigned sent;
        int unsigned burst;
        logic [W-1:0] modulus;
        logic [W-1:0] exponent;
        logic [W-1:0] base;
        sent = 0;
        while (sent < n_items) begin
            case ($urandom_range(9))
                0: modulus = '0;
                1: modulus = $urandom_range(64, 1);
                2: modulus = 32'hFFFF_FFFF;
                default: modulus = $urandom;
            endcase
            // most exponents short to keep the run length down
            case ($urandom_range(9))
                0: exponent = '0;
                1: exponent = rand_exponent(W);
                2: exponent = rand_exponent($urandom_range(31, 13));
                default: exponent = rand_exponent($urandom_range(12, 1));
            endcase
            set_key(modulus, exponent);
            burst = $urandom_range(18, 6);
            for (int unsigned k = 0; k < burst && sent < n_items; k++) begin
                case ($urandom_range(7))
                    0: base = '0;
                    1: base = key_modulus;
                    2: base = key_modulus - 32'd1;
                    3: base = $urandom_range(3, 0);
                    default: base = $urandom;
                endcase
                send_base(base);
                sent++;
            end
        end
    endtask

    always @(negedge i_clk) begin
        i_out_stall <= ($urandom_range(99) < sink_stall_pct);
    end

    always @(posedge i_clk) begin
        t_power want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_powers.size() == 0) begin
                $error("result transaction with nothing expected: power_result %h", o_power_result);
                mismatch_count++;
            end else begin
                want = pending_powers.pop_front();
                if (o_power_result !== want.power) begin
                    $error("power_result: expected %h, actual %h", want.power, o_power_result);
                    mismatch_count++;
                end
                if (o_modulus_error !== want.err) begin
                    $error("modulus_error: expected %b, actual %b", want.err, o_modulus_error);
                    mismatch_count++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("FAIL modular_exponentiation");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        send_gap_pct = 29;
        sink_stall_pct = 83;
        test_reset_values();
        test_zero_modulus();
        test_zero_exponent();
        test_extremes();
        test_rsa_keys();
        test_random(87);

        send_gap_pct = 83;
        sink_stall_pct = 29;
        test_random(87);

        send_gap_pct = 0;
        sink_stall_pct = 0;
        test_random(87);

        drain_results();
        repeat (50) @(posedge i_clk);
        if (mismatch_count == 0 && pending_powers.size() == 0) begin
            $display("PASS modular_exponentiation");
        end else begin
            $display("FAIL modular_exponentiation");
        end
        $finish;
    end
endmodule

### sim.f
rtl/mexp_pkg.sv
rtl/modular_exponentiation.sv
rtl/mexp_checker.sv
tb/tb_top.sv
